// ===== rtl/mfb_pkg.sv =====
// Package for the maximum flow block: sizes, datapath operation codes and
// the status struct shared by controller and datapath. No dependencies.
package mfb_pkg;

  localparam int unsigned MAX_VERTICES = 64;
  localparam int unsigned MAX_EDGES    = 256;
  localparam int unsigned ARC_SLOTS    = 2 * MAX_EDGES;

  localparam int unsigned V_W     = $clog2(MAX_VERTICES);  // vertex number
  localparam int unsigned E_W     = $clog2(MAX_EDGES);     // edge slot index
  localparam int unsigned ARC_W   = $clog2(ARC_SLOTS);     // arc slot index
  localparam int unsigned CNT_W   = E_W + 1;               // edge count
  localparam int unsigned ACNT_W  = ARC_W + 1;             // arc sweep counter
  localparam int unsigned QCNT_W  = V_W + 1;               // queue pointers
  localparam int unsigned CAP_W   = 32;
  localparam int unsigned FLOW_W  = 40;
  localparam int unsigned OP_W    = 2;

  // Input operation codes
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
  localparam logic [OP_W-1:0] OP_RUN   = 2'd2;

  // Datapath operations issued by the controller each cycle
  typedef enum logic [4:0] {
    DP_NOP,
    DP_CLEAR,
    DP_ADD,
    DP_LATCH,
    DP_INIT_RD,
    DP_INIT_WR,
    DP_BFS_START,
    DP_DEQ_RD,
    DP_DEQ_LOAD,
    DP_SCAN_RD,
    DP_SCAN_CHK,
    DP_WALK_RD,
    DP_WALK_P,
    DP_WALK_E0,
    DP_WALK_E1,
    DP_WALK_R2,
    DP_WALK_W2,
    DP_REWALK,
    DP_ADD_TOTAL
  } dp_op_e;

  // Datapath status seen by the controller
  typedef struct packed {
    logic same_ends;  // source equals sink
    logic sweep_end;  // arc counter reached twice the edge count
    logic q_empty;    // search queue exhausted
    logic hit_sink;   // scanned arc reaches the sink
    logic at_src;     // path walk reached the source
  } dp_status_t;

endpackage

// ===== rtl/mfb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mfb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port; read data holds when not enabled
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mfb_dp.sv =====
// Datapath of the maximum flow block: edge, capacity, residual, queue and
// parent memories, search registers and the flow total. Uses mfb_pkg, mfb_ram.
module mfb_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mfb_pkg::dp_op_e             op_i,
  input  logic [mfb_pkg::V_W-1:0]     tail_vertex_i,
  input  logic [mfb_pkg::V_W-1:0]     head_vertex_i,
  input  logic [mfb_pkg::CAP_W-1:0]   capacity_i,
  input  logic [mfb_pkg::V_W-1:0]     source_vertex_i,
  input  logic [mfb_pkg::V_W-1:0]     sink_vertex_i,
  output mfb_pkg::dp_status_t         status_o,
  output logic [mfb_pkg::FLOW_W-1:0]  max_flow_o,
  output logic                        edges_dropped_o
);

  localparam int unsigned V_W    = mfb_pkg::V_W;
  localparam int unsigned E_W    = mfb_pkg::E_W;
  localparam int unsigned ARC_W  = mfb_pkg::ARC_W;
  localparam int unsigned CNT_W  = mfb_pkg::CNT_W;
  localparam int unsigned ACNT_W = mfb_pkg::ACNT_W;
  localparam int unsigned QCNT_W = mfb_pkg::QCNT_W;
  localparam int unsigned CAP_W  = mfb_pkg::CAP_W;
  localparam int unsigned FLOW_W = mfb_pkg::FLOW_W;
  localparam int unsigned NV     = mfb_pkg::MAX_VERTICES;

  // control registers
  logic [CNT_W-1:0]  edge_count_q;
  logic              overflow_q;
  // search registers (payload)
  logic [V_W-1:0]    src_q, snk_q, u_q, v_q;
  logic [ACNT_W-1:0] idx_q;
  logic [QCNT_W-1:0] qh_q, qt_q;
  logic [ARC_W-1:0]  arc_q;
  logic [CAP_W-1:0]  neck_q;
  logic [FLOW_W-1:0] total_q;
  logic [NV-1:0]     reached_q;

  // memory ports
  logic              edge_re, cap_re, room_we, room_re, q_we, q_re, par_we, par_re;
  logic [E_W-1:0]    edge_raddr, cap_raddr;
  logic [2*V_W-1:0]  edge_rd;
  logic [CAP_W-1:0]  cap_rd, room_rd, room_wdata;
  logic [ARC_W-1:0]  room_waddr, room_raddr, par_rd;
  logic [V_W-1:0]    q_waddr, q_wdata, q_rd;
  logic [V_W-1:0]    edge_from_rd, edge_to_rd, arc_tail, arc_head, path_tail;
  logic              add_ok, hit;
  logic [ACNT_W-1:0] arc_total;

  assign edge_from_rd = edge_rd[2*V_W-1:V_W];
  assign edge_to_rd   = edge_rd[V_W-1:0];
  // odd arcs run against their edge
  assign arc_tail  = idx_q[0] ? edge_to_rd : edge_from_rd;
  assign arc_head  = idx_q[0] ? edge_from_rd : edge_to_rd;
  assign path_tail = arc_q[0] ? edge_to_rd : edge_from_rd;
  assign arc_total = {edge_count_q, 1'b0};
  assign add_ok    = (edge_count_q != CNT_W'(mfb_pkg::MAX_EDGES));

  // an arc with room leaving the current vertex to an unreached vertex
  assign hit = (arc_tail == u_q) && (room_rd != '0) && !reached_q[arc_head];

  // memory address and enable selection
  always_comb begin
    edge_re    = 1'b0;
    edge_raddr = idx_q[ARC_W-1:1];
    cap_re     = (op_i == mfb_pkg::DP_INIT_RD);
    cap_raddr  = idx_q[ARC_W-1:1];
    room_re    = 1'b0;
    room_raddr = idx_q[ARC_W-1:0];
    room_we    = 1'b0;
    room_waddr = idx_q[ARC_W-1:0];
    room_wdata = idx_q[0] ? '0 : cap_rd;
    q_we       = 1'b0;
    q_waddr    = qt_q[V_W-1:0];
    q_wdata    = arc_head;
    q_re       = (op_i == mfb_pkg::DP_DEQ_RD);
    par_we     = (op_i == mfb_pkg::DP_SCAN_CHK) && hit;
    par_re     = (op_i == mfb_pkg::DP_WALK_RD);
    case (op_i)
      mfb_pkg::DP_INIT_WR: begin
        room_we = 1'b1;
      end
      mfb_pkg::DP_BFS_START: begin
        q_we    = 1'b1;
        q_waddr = '0;
        q_wdata = src_q;
      end
      mfb_pkg::DP_SCAN_RD: begin
        edge_re = 1'b1;
        room_re = 1'b1;
      end
      mfb_pkg::DP_SCAN_CHK: begin
        q_we = hit;
      end
      mfb_pkg::DP_WALK_P: begin
        edge_re    = 1'b1;
        edge_raddr = par_rd[ARC_W-1:1];
        room_re    = 1'b1;
        room_raddr = par_rd;
      end
      mfb_pkg::DP_WALK_E1: begin
        room_we    = 1'b1;
        room_waddr = arc_q;
        room_wdata = room_rd - neck_q;
      end
      mfb_pkg::DP_WALK_R2: begin
        room_re    = 1'b1;
        room_raddr = arc_q ^ ARC_W'(1);
      end
      mfb_pkg::DP_WALK_W2: begin
        room_we    = 1'b1;
        room_waddr = arc_q ^ ARC_W'(1);
        room_wdata = room_rd + neck_q;
      end
      default: begin
      end
    endcase
  end

  // graph store control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_count_q <= '0;
      overflow_q   <= 1'b0;
    end else begin
      if (op_i == mfb_pkg::DP_CLEAR) begin
        edge_count_q <= '0;
        overflow_q   <= 1'b0;
      end else if (op_i == mfb_pkg::DP_ADD) begin
        if (add_ok) begin
          edge_count_q <= edge_count_q + CNT_W'(1);
        end else begin
          overflow_q <= 1'b1;
        end
      end
    end
  end

  // search and walk registers
  always_ff @(posedge clk_i) begin
    case (op_i)
      mfb_pkg::DP_LATCH: begin
        src_q   <= source_vertex_i;
        snk_q   <= sink_vertex_i;
        total_q <= '0;
        idx_q   <= '0;
      end
      mfb_pkg::DP_INIT_WR: begin
        idx_q <= idx_q + ACNT_W'(1);
      end
      mfb_pkg::DP_BFS_START: begin
        // only the source is marked reached
        reached_q <= NV'(1) << src_q;
        qh_q      <= '0;
        qt_q      <= QCNT_W'(1);
      end
      mfb_pkg::DP_DEQ_RD: begin
        qh_q <= qh_q + QCNT_W'(1);
      end
      mfb_pkg::DP_DEQ_LOAD: begin
        u_q   <= q_rd;
        idx_q <= '0;
      end
      mfb_pkg::DP_SCAN_CHK: begin
        idx_q <= idx_q + ACNT_W'(1);
        if (hit) begin
          reached_q[arc_head] <= 1'b1;
          qt_q                <= qt_q + QCNT_W'(1);
        end
        // set up the bottleneck walk from the sink; used once the sink is found
        v_q    <= snk_q;
        neck_q <= '1;
      end
      mfb_pkg::DP_WALK_P: begin
        arc_q <= par_rd;
      end
      mfb_pkg::DP_WALK_E0: begin
        if (room_rd < neck_q) begin
          neck_q <= room_rd;
        end
        v_q <= path_tail;
      end
      mfb_pkg::DP_WALK_E1: begin
        v_q <= path_tail;
      end
      mfb_pkg::DP_REWALK: begin
        v_q <= snk_q;
      end
      mfb_pkg::DP_ADD_TOTAL: begin
        total_q <= total_q + FLOW_W'(neck_q);
      end
      default: begin
      end
    endcase
  end

  // edge endpoints, forward capacities, residual room, queue, parent arcs
  mfb_ram #(.WIDTH(2 * V_W), .DEPTH(mfb_pkg::MAX_EDGES)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    ((op_i == mfb_pkg::DP_ADD) && add_ok),
    .waddr_i (edge_count_q[E_W-1:0]),
    .wdata_i ({tail_vertex_i, head_vertex_i}),
    .re_i    (edge_re),
    .raddr_i (edge_raddr),
    .rdata_o (edge_rd)
  );

  mfb_ram #(.WIDTH(CAP_W), .DEPTH(mfb_pkg::MAX_EDGES)) u_cap_ram (
    .clk_i   (clk_i),
    .we_i    ((op_i == mfb_pkg::DP_ADD) && add_ok),
    .waddr_i (edge_count_q[E_W-1:0]),
    .wdata_i (capacity_i),
    .re_i    (cap_re),
    .raddr_i (cap_raddr),
    .rdata_o (cap_rd)
  );

  mfb_ram #(.WIDTH(CAP_W), .DEPTH(mfb_pkg::ARC_SLOTS)) u_room_ram (
    .clk_i   (clk_i),
    .we_i    (room_we),
    .waddr_i (room_waddr),
    .wdata_i (room_wdata),
    .re_i    (room_re),
    .raddr_i (room_raddr),
    .rdata_o (room_rd)
  );

  mfb_ram #(.WIDTH(V_W), .DEPTH(NV)) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .re_i    (q_re),
    .raddr_i (qh_q[V_W-1:0]),
    .rdata_o (q_rd)
  );

  mfb_ram #(.WIDTH(ARC_W), .DEPTH(NV)) u_parent_ram (
    .clk_i   (clk_i),
    .we_i    (par_we),
    .waddr_i (arc_head),
    .wdata_i (idx_q[ARC_W-1:0]),
    .re_i    (par_re),
    .raddr_i (v_q),
    .rdata_o (par_rd)
  );

  // status towards the controller
  assign status_o.same_ends = (src_q == snk_q);
  assign status_o.sweep_end = (idx_q == arc_total);
  assign status_o.q_empty   = (qh_q == qt_q);
  assign status_o.hit_sink  = hit && (arc_head == snk_q);
  assign status_o.at_src    = (v_q == src_q);

  assign max_flow_o      = total_q;
  assign edges_dropped_o = overflow_q;

endmodule

// ===== rtl/mfb_ctrl.sv =====
// Controller of the maximum flow block: sequences residual set-up, search,
// bottleneck walk and augment walk. Uses mfb_pkg.
module mfb_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [mfb_pkg::OP_W-1:0]   operation_i,
  input  mfb_pkg::dp_status_t        status_i,
  output mfb_pkg::dp_op_e            op_o,
  output logic                       busy_o,
  output logic                       result_valid_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_RUN_CHK, S_INIT_RD, S_INIT_WR, S_BFS_START, S_DEQ_RD, S_DEQ_LOAD,
    S_SCAN_RD, S_SCAN_CHK, S_W0_RD, S_W0_P, S_W0_E, S_W1_RD, S_W1_P, S_W1_E,
    S_W1_R2, S_W1_W2, S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   valid_q;

  // next state and datapath operation
  always_comb begin
    state_d = state_q;
    op_o    = mfb_pkg::DP_NOP;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (operation_i)
            mfb_pkg::OP_CLEAR: op_o = mfb_pkg::DP_CLEAR;
            mfb_pkg::OP_ADD:   op_o = mfb_pkg::DP_ADD;
            mfb_pkg::OP_RUN: begin
              op_o    = mfb_pkg::DP_LATCH;
              state_d = S_RUN_CHK;
            end
            default: op_o = mfb_pkg::DP_NOP;
          endcase
        end
      end
      S_RUN_CHK: state_d = status_i.same_ends ? S_DONE : S_INIT_RD;
      S_INIT_RD: begin
        if (status_i.sweep_end) begin
          state_d = S_BFS_START;
        end else begin
          op_o    = mfb_pkg::DP_INIT_RD;
          state_d = S_INIT_WR;
        end
      end
      S_INIT_WR: begin
        op_o    = mfb_pkg::DP_INIT_WR;
        state_d = S_INIT_RD;
      end
      S_BFS_START: begin
        op_o    = mfb_pkg::DP_BFS_START;
        state_d = S_DEQ_RD;
      end
      S_DEQ_RD: begin
        if (status_i.q_empty) begin
          state_d = S_DONE;
        end else begin
          op_o    = mfb_pkg::DP_DEQ_RD;
          state_d = S_DEQ_LOAD;
        end
      end
      S_DEQ_LOAD: begin
        op_o    = mfb_pkg::DP_DEQ_LOAD;
        state_d = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        if (status_i.sweep_end) begin
          state_d = S_DEQ_RD;
        end else begin
          op_o    = mfb_pkg::DP_SCAN_RD;
          state_d = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        op_o    = mfb_pkg::DP_SCAN_CHK;
        state_d = status_i.hit_sink ? S_W0_RD : S_SCAN_RD;
      end
      // first walk: bottleneck
      S_W0_RD: begin
        if (status_i.at_src) begin
          op_o    = mfb_pkg::DP_REWALK;
          state_d = S_W1_RD;
        end else begin
          op_o    = mfb_pkg::DP_WALK_RD;
          state_d = S_W0_P;
        end
      end
      S_W0_P: begin
        op_o    = mfb_pkg::DP_WALK_P;
        state_d = S_W0_E;
      end
      S_W0_E: begin
        op_o    = mfb_pkg::DP_WALK_E0;
        state_d = S_W0_RD;
      end
      // second walk: push the bottleneck along the path
      S_W1_RD: begin
        if (status_i.at_src) begin
          op_o    = mfb_pkg::DP_ADD_TOTAL;
          state_d = S_BFS_START;
        end else begin
          op_o    = mfb_pkg::DP_WALK_RD;
          state_d = S_W1_P;
        end
      end
      S_W1_P: begin
        op_o    = mfb_pkg::DP_WALK_P;
        state_d = S_W1_E;
      end
      S_W1_E: begin
        op_o    = mfb_pkg::DP_WALK_E1;
        state_d = S_W1_R2;
      end
      S_W1_R2: begin
        op_o    = mfb_pkg::DP_WALK_R2;
        state_d = S_W1_W2;
      end
      S_W1_W2: begin
        op_o    = mfb_pkg::DP_WALK_W2;
        state_d = S_W1_RD;
      end
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // state and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= (state_d == S_DONE);
    end
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = valid_q;

endmodule

// ===== rtl/max_flow_bfs_augment.sv =====
// Top level of the maximum flow block (shortest augmenting paths).
// Depends on mfb_pkg, mfb_ctrl, mfb_dp (which uses mfb_ram).
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------------
//  command  | start & !busy          | operation, tail/head_vertex, capacity,
//           |                        | source_vertex, sink_vertex (_i)
//  result   | result_valid_o strobe  | max_flow_o, edges_dropped_o
//
// Clear and add edge leave busy low. A run sets up the residual memory with a
// read and a write per arc, then each search sweeps every stored arc for each
// dequeued vertex until the sink is hit, and each path found is walked for the
// bottleneck and again for the augment, which also writes the reverse arcs.
// Reset is asynchronous, active low; the result strobe lasts one cycle and
// the receiver cannot stall it.
module max_flow_bfs_augment (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [mfb_pkg::OP_W-1:0]    operation_i,
  input  logic [mfb_pkg::V_W-1:0]     tail_vertex_i,
  input  logic [mfb_pkg::V_W-1:0]     head_vertex_i,
  input  logic [mfb_pkg::CAP_W-1:0]   capacity_i,
  input  logic [mfb_pkg::V_W-1:0]     source_vertex_i,
  input  logic [mfb_pkg::V_W-1:0]     sink_vertex_i,
  output logic                        result_valid_o,
  output logic [mfb_pkg::FLOW_W-1:0]  max_flow_o,
  output logic                        edges_dropped_o
);

  mfb_pkg::dp_op_e     dp_op;
  mfb_pkg::dp_status_t dp_status;

  mfb_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .operation_i    (operation_i),
    .status_i       (dp_status),
    .op_o           (dp_op),
    .busy_o         (busy),
    .result_valid_o (result_valid_o)
  );

  mfb_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .op_i            (dp_op),
    .tail_vertex_i   (tail_vertex_i),
    .head_vertex_i   (head_vertex_i),
    .capacity_i      (capacity_i),
    .source_vertex_i (source_vertex_i),
    .sink_vertex_i   (sink_vertex_i),
    .status_o        (dp_status),
    .max_flow_o      (max_flow_o),
    .edges_dropped_o (edges_dropped_o)
  );

endmodule

// ===== tb/tb_max_flow_bfs_augment.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for max_flow_bfs_augment: clear, add edge and run
// commands are checked against a behavioural max-flow solver.
// Depends on mfb_pkg and the max_flow_bfs_augment RTL.
module tb_max_flow_bfs_augment;

  localparam int unsigned OP_W         = mfb_pkg::OP_W;
  localparam int unsigned V_W          = mfb_pkg::V_W;
  localparam int unsigned CAP_W        = mfb_pkg::CAP_W;
  localparam int unsigned FLOW_W       = mfb_pkg::FLOW_W;
  localparam int unsigned MAX_EDGES    = mfb_pkg::MAX_EDGES;
  localparam int unsigned MAX_VERTICES = mfb_pkg::MAX_VERTICES;

  localparam logic [OP_W-1:0] OP_CLEAR  = mfb_pkg::OP_CLEAR;
  localparam logic [OP_W-1:0] OP_ADD    = mfb_pkg::OP_ADD;
  localparam logic [OP_W-1:0] OP_RUN    = mfb_pkg::OP_RUN;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;  // spare code, ignored

  localparam int unsigned CYCLE_LIMIT = 100_000_000;
  localparam int unsigned ITEM_GOAL   = 1100;

  typedef struct {
    logic [OP_W-1:0]  op;
    logic [V_W-1:0]   tail;
    logic [V_W-1:0]   head;
    logic [CAP_W-1:0] cap;
    logic [V_W-1:0]   src;
    logic [V_W-1:0]   snk;
    bit               drain;  // hold off until all flow results are back
    bit               calm;   // no idle gaps before this command
  } cmd_t;

  typedef struct {
    logic [FLOW_W-1:0] flow;
    logic              dropped;
  } flow_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [OP_W-1:0]     operation_i;
  logic [V_W-1:0]      tail_vertex_i;
  logic [V_W-1:0]      head_vertex_i;
  logic [CAP_W-1:0]    capacity_i;
  logic [V_W-1:0]      source_vertex_i;
  logic [V_W-1:0]      sink_vertex_i;
  logic                result_valid_o;
  logic [FLOW_W-1:0]   max_flow_o;
  logic                edges_dropped_o;

  cmd_t         cmd_q[$];
  flow_result_t flow_expect_q[$];
  int unsigned  err_count;
  int unsigned  cycle_count;
  int unsigned  gap_left;
  cmd_t         cur_cmd;

  // Shadow edge store
  logic [V_W-1:0]   g_tail[MAX_EDGES];
  logic [V_W-1:0]   g_head[MAX_EDGES];
  logic [CAP_W-1:0] g_cap[MAX_EDGES];
  int unsigned      g_count;
  bit               g_dropped;

  max_flow_bfs_augment dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .operation_i(operation_i), .tail_vertex_i(tail_vertex_i),
    .head_vertex_i(head_vertex_i), .capacity_i(capacity_i),
    .source_vertex_i(source_vertex_i), .sink_vertex_i(sink_vertex_i),
    .result_valid_o(result_valid_o), .max_flow_o(max_flow_o),
    .edges_dropped_o(edges_dropped_o)
  );

  // Arc 2k runs along edge k, arc 2k+1 against it
  function automatic int arc_from(int a);
    return (a & 1) ? int'(g_head[a >> 1]) : int'(g_tail[a >> 1]);
  endfunction

  function automatic int arc_to(int a);
    return (a & 1) ? int'(g_tail[a >> 1]) : int'(g_head[a >> 1]);
  endfunction

  function automatic longint arc_cap(int a);
    return (a & 1) ? 64'sd0 : longint'({32'd0, g_cap[a >> 1]});
  endfunction

  // Shortest augmenting paths on the shadow store
  function automatic logic [FLOW_W-1:0] solve_flow(int s, int t);
    longint flow[2*MAX_EDGES];
    int     parent[MAX_VERTICES];
    bit     seen[MAX_VERTICES];
    int     fifo[$];
    int     u, v, a, w;
    longint room, neck, total;
    bit     hit;
    total = 0;
    if (s == t) return '0;
    for (a = 0; a < 2 * g_count; a++) flow[a] = 0;
    while (1) begin
      foreach (seen[i]) seen[i] = 0;
      fifo.delete();
      seen[s] = 1;
      fifo = {fifo, s};
      hit = 0;
      while (fifo.size() > 0 && !hit) begin
        u = fifo.pop_front();
        for (a = 0; a < 2 * g_count && !hit; a++) begin
          if (arc_from(a) == u) begin
            w = arc_to(a);
            room = arc_cap(a) - flow[a];
            if (room > 0 && !seen[w]) begin
              seen[w] = 1;
              parent[w] = a;
              fifo = {fifo, w};
              if (w == t) hit = 1;
            end
          end
        end
      end
      if (!hit) break;
      neck = 64'h7fff_ffff_ffff_ffff;
      for (v = t; v != s; v = arc_from(parent[v])) begin
        room = arc_cap(parent[v]) - flow[parent[v]];
        if (room < neck) neck = room;
      end
      for (v = t; v != s; v = arc_from(parent[v])) begin
        flow[parent[v]] += neck;
        flow[parent[v] ^ 1] -= neck;
      end
      total += neck;
    end
    return total[FLOW_W-1:0];
  endfunction

  // Apply one accepted transaction to the shadow state
  task automatic apply_cmd(cmd_t c);
    flow_result_t r;
    case (c.op)
      OP_CLEAR: begin
        g_count = 0;
        g_dropped = 0;
      end
      OP_ADD: begin
        if (g_count >= MAX_EDGES) g_dropped = 1;
        else begin
          g_tail[g_count] = c.tail;
          g_head[g_count] = c.head;
          g_cap[g_count]  = c.cap;
          g_count++;
        end
      end
      OP_RUN: begin
        r.flow = solve_flow(int'(c.src), int'(c.snk));
        r.dropped = g_dropped;
        flow_expect_q = {flow_expect_q, r};
      end
      default: ;
    endcase
  endtask

  task automatic push_cmd(logic [OP_W-1:0] op, int tl, int hd, logic [CAP_W-1:0] cap,
                          int s, int t, bit drain = 0);
    cmd_t c;
    c.op = op;
    c.tail = V_W'(tl);
    c.head = V_W'(hd);
    c.cap = cap;
    c.src = V_W'(s);
    c.snk = V_W'(t);
    c.calm = (cmd_q.size() >= ITEM_GOAL - 100);
    c.drain = drain && !c.calm;
    cmd_q = {cmd_q, c};
  endtask

  function automatic logic [CAP_W-1:0] pick_cap();
    case ($urandom_range(0, 5))
      0:       return '1;
      1:       return '0;
      2, 3:    return $urandom();
      default: return $urandom_range(1, 20);
    endcase
  endfunction

  function automatic int pick_vertex();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 7);
  endfunction

  // Clock
  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  // Stimulus list and end of run
  initial begin
    int n, k;
    rst_ni = 0;
    err_count = 0;
    g_count = 0;
    g_dropped = 0;
    // directed: empty graph, wide totals, same ends, top vertices, zero cap
    push_cmd(OP_RUN, 0, 0, 0, 0, 1);
    push_cmd(OP_CLEAR, 63, 63, '1, 63, 63);
    for (k = 0; k < 3; k++) push_cmd(OP_ADD, 0, 1, '1, 0, 0);
    for (k = 0; k < 3; k++) push_cmd(OP_ADD, 1, 2, '1, 0, 0);
    push_cmd(OP_RUN, 0, 0, 0, 0, 2);
    push_cmd(OP_RUN, 0, 0, 0, 2, 0);
    push_cmd(OP_RUN, 0, 0, 0, 5, 5);
    push_cmd(OP_ADD, 2, 2, 7, 0, 0);
    push_cmd(OP_ADD, 2, 63, 0, 0, 0);
    push_cmd(OP_ADD, 63, 62, 9, 0, 0);
    push_cmd(OP_RUN, 0, 0, 0, 0, 63);
    push_cmd(OP_RUN, 0, 0, 0, 63, 62);
    push_cmd(OP_UNUSED, 0, 1, 5, 0, 1);
    push_cmd(OP_RUN, 63, 63, '1, 63, 0, 1);
    // random phases of graph loads followed by runs
    while (cmd_q.size() < ITEM_GOAL) begin
      if ($urandom_range(0, 3) != 0) push_cmd(OP_CLEAR, $urandom_range(0, 63),
          $urandom_range(0, 63), $urandom(), $urandom_range(0, 63), $urandom_range(0, 63));
      if ($urandom_range(0, 40) == 0 && cmd_q.size() + MAX_EDGES + 20 < ITEM_GOAL) begin
        // fill the store past its end with edges among vertices 40 to 63
        for (k = 0; k <= MAX_EDGES; k++)
          push_cmd(OP_ADD, $urandom_range(40, 63), $urandom_range(40, 63), pick_cap(),
                   $urandom_range(0, 63), $urandom_range(0, 63));
        push_cmd(OP_RUN, 0, 0, 0, 0, 1);
        push_cmd(OP_RUN, 0, 0, 0, $urandom_range(0, 1), $urandom_range(40, 63));
      end else begin
        n = $urandom_range(1, 16);
        for (k = 0; k < n; k++)
          push_cmd(OP_ADD, pick_vertex(), pick_vertex(), pick_cap(),
                   $urandom_range(0, 63), $urandom_range(0, 63));
      end
      if ($urandom_range(0, 9) == 0)
        push_cmd(OP_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63), $urandom(),
                 $urandom_range(0, 63), $urandom_range(0, 63));
      n = $urandom_range(1, 4);
      for (k = 0; k < n; k++)
        push_cmd(OP_RUN, $urandom_range(0, 63), $urandom_range(0, 63), $urandom(),
                 pick_vertex(), pick_vertex(), $urandom_range(0, 60) == 0);
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    while (cmd_q.size() != 0 || start || flow_expect_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (err_count == 0) $display("tb_max_flow_bfs_augment: done, clean");
    else $display("tb_max_flow_bfs_augment: done, errors");
    $finish;
  end

  // Driver: issue queued commands, with random idle bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start           <= 0;
      operation_i     <= OP_CLEAR;
      tail_vertex_i   <= '0;
      head_vertex_i   <= '0;
      capacity_i      <= '0;
      source_vertex_i <= '0;
      sink_vertex_i   <= '0;
      gap_left        <= 0;
    end else if (start && busy) begin
      // hold the transaction until accepted
    end else begin
      if (start) apply_cmd(cur_cmd);
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        start <= 0;
      end else if (cmd_q.size() == 0 || (cmd_q[0].drain && flow_expect_q.size() != 0)) begin
        start <= 0;
      end else if (!cmd_q[0].calm && $urandom_range(0, 5) == 0) begin
        gap_left <= $urandom_range(0, 14);
        start <= 0;
      end else begin
        cur_cmd = cmd_q.pop_front();
        start           <= 1;
        operation_i     <= cur_cmd.op;
        tail_vertex_i   <= cur_cmd.tail;
        head_vertex_i   <= cur_cmd.head;
        capacity_i      <= cur_cmd.cap;
        source_vertex_i <= cur_cmd.src;
        sink_vertex_i   <= cur_cmd.snk;
      end
    end
  end

  // Monitor: compare each flow result with the oldest expectation
  always @(posedge clk_i) begin
    flow_result_t exp_r;
    if (rst_ni && result_valid_o) begin
      if (flow_expect_q.size() == 0) begin
        $error("unexpected result: max_flow %0d edges_dropped %0b",
               max_flow_o, edges_dropped_o);
        err_count++;
      end else begin
        exp_r = flow_expect_q.pop_front();
        if (max_flow_o !== exp_r.flow) begin
          $error("max_flow: expected %0d, got %0d", exp_r.flow, max_flow_o);
          err_count++;
        end
        if (edges_dropped_o !== exp_r.dropped) begin
          $error("edges_dropped: expected %0b, got %0b", exp_r.dropped, edges_dropped_o);
          err_count++;
        end
      end
    end
  end

  // Timeout
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_max_flow_bfs_augment: done, errors");
      $finish;
    end
  end

  initial cycle_count = 0;

endmodule
